@@ sv/sdfa_pkg.sv @@
// Shared types, constants and the identifier table for the section deframer.
// Used by every module of the deframer; depends on nothing.
`default_nettype none

package sdfa_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned STAT_W  = 3;

    localparam logic [SUM_W:0]    ADLER_MOD = 17'd65521;
    localparam logic [WORD_W-1:0] MIN_TOTAL = 32'd13;
    localparam logic [POS_W-1:0]  IDENT_LEN = 4'd12;
    localparam logic [POS_W-1:0]  HDR_LAST  = 4'd8;
    localparam logic [POS_W-1:0]  SUM_LAST  = 4'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_IDENT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_SHORT    = 3'd3;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd4;
    localparam logic [STAT_W-1:0] ST_SCHEME   = 3'd5;
    localparam logic [STAT_W-1:0] ST_CHECKSUM = 3'd6;
    localparam logic [STAT_W-1:0] ST_TRUNC    = 3'd7;

    localparam logic [BYTE_W-1:0] SCHEME_RAW  = 8'd0;
    localparam logic [BYTE_W-1:0] SCHEME_COMP = 8'd1;

    typedef struct packed {
        logic [SUM_W-1:0] low;
        logic [SUM_W-1:0] high;
    } t_adler;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_compressed;
        logic              payload_last;
        logic              status_valid;
        logic [STAT_W-1:0] status;
    } t_result;

    function automatic logic [BYTE_W-1:0] ident_byte(input logic [POS_W-1:0] idx);
        logic [BYTE_W-1:0] v;
        unique case (idx)
            4'd0:    v = 8'hAB;
            4'd1:    v = 8'h4A;
            4'd2:    v = 8'h53;
            4'd3:    v = 8'h52;
            4'd4:    v = 8'h31;
            4'd5:    v = 8'h38;
            4'd6:    v = 8'h34;
            4'd7:    v = 8'hBB;
            4'd8:    v = 8'h0D;
            4'd9:    v = 8'h0A;
            4'd10:   v = 8'h1A;
            4'd11:   v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/sdfa_if.sv @@
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on sdfa_pkg for the field widths.
`default_nettype none

interface sdfa_in_if;
    import sdfa_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface sdfa_out_if;
    import sdfa_pkg::*;
    logic              valid;
    logic              ready;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_compressed;
    logic              payload_last;
    logic              status_valid;
    logic [STAT_W-1:0] status;
    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_compressed, output payload_last,
                    output status_valid, output status, input ready);
    modport sink (input valid, input payload_valid, input payload_byte,
                  input payload_compressed, input payload_last,
                  input status_valid, input status, output ready);
endinterface

`default_nettype wire

@@ sv/sdfa_adler.sv @@
// One Adler-32 byte update with both sums reduced modulo 65521.
// Depends on sdfa_pkg.
`default_nettype none

module sdfa_adler
    import sdfa_pkg::*;
(
    input  wire t_adler            i_sum,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_adler                 o_sum
);

    logic [SUM_W:0] low_raw;
    logic [SUM_W:0] low_red;
    logic [SUM_W:0] high_raw;
    logic [SUM_W:0] high_red;

    always_comb begin
        low_raw  = {1'b0, i_sum.low} + {{(SUM_W + 1 - BYTE_W){1'b0}}, i_byte};
        low_red  = (low_raw >= ADLER_MOD) ? (low_raw - ADLER_MOD) : low_raw;
        high_raw = {1'b0, i_sum.high} + low_red;
        high_red = (high_raw >= ADLER_MOD) ? (high_raw - ADLER_MOD) : high_raw;
        o_sum.low  = low_red[SUM_W-1:0];
        o_sum.high = high_red[SUM_W-1:0];
    end

endmodule

`default_nettype wire

@@ sv/sdfa_parse.sv @@
// Section parser: identifier check, header decode, payload pass and checksum
// compare, one byte per step. Depends on sdfa_pkg and sdfa_adler.
`default_nettype none

module sdfa_parse
    import sdfa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_last,
    output t_result                o_res
);

    localparam logic [2:0] PH_IDENT   = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_CHECK   = 3'd3;
    localparam logic [2:0] PH_DROP    = 3'd4;

    logic [2:0]          r_phase,  n_phase;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [BYTE_W-1:0]   r_scheme, n_scheme;
    logic [WORD_W-1:0]   r_total,  n_total;
    logic [23:0]         r_plain,  n_plain;
    logic [WORD_W-2:0]   r_remain, n_remain;
    logic [23:0]         r_expect, n_expect;
    t_adler              r_sum,    n_sum;
    t_adler              sum_upd;
    logic [WORD_W-1:0]   plain_full;
    logic [WORD_W-1:0]   body_len;
    t_result             res;

    sdfa_adler u_adler (
        .i_sum  (r_sum),
        .i_byte (i_byte),
        .o_sum  (sum_upd)
    );

    always_comb begin
        plain_full = {i_byte, r_plain};
        body_len   = r_total - MIN_TOTAL;
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_scheme = r_scheme;
        n_total  = r_total;
        n_plain  = r_plain;
        n_remain = r_remain;
        n_expect = r_expect;
        n_sum    = r_sum;
        res      = '0;

        unique case (r_phase)
            PH_IDENT: begin
                if (r_pos < IDENT_LEN && i_byte == ident_byte(r_pos)) begin
                    n_pos = r_pos + 4'd1;
                    if (n_pos == IDENT_LEN) begin
                        n_phase = PH_HEADER;
                        n_pos   = '0;
                    end
                end else begin
                    res.status_valid = 1'b1;
                    res.status       = ST_IDENT;
                end
            end
            PH_HEADER: begin
                n_sum = sum_upd;
                n_pos = r_pos + 4'd1;
                case (r_pos)
                    4'd0: n_scheme = i_byte;
                    4'd1: n_total[7:0]   = i_byte;
                    4'd2: n_total[15:8]  = i_byte;
                    4'd3: n_total[23:16] = i_byte;
                    4'd4: n_total[31:24] = i_byte;
                    4'd5: n_plain[7:0]   = i_byte;
                    4'd6: n_plain[15:8]  = i_byte;
                    4'd7: n_plain[23:16] = i_byte;
                    default: ;
                endcase
                if (r_pos >= HDR_LAST) begin
                    res.status_valid = 1'b1;
                    if (r_total[WORD_W-1] || i_byte[BYTE_W-1]) begin
                        res.status = ST_RANGE;
                    end else if (r_total < MIN_TOTAL) begin
                        res.status = ST_SHORT;
                    end else if (r_scheme == SCHEME_RAW && body_len != plain_full) begin
                        res.status = ST_MISMATCH;
                    end else if (r_scheme > SCHEME_COMP) begin
                        res.status = ST_SCHEME;
                    end else begin
                        res.status_valid = 1'b0;
                        n_phase  = (r_total == MIN_TOTAL) ? PH_CHECK : PH_PAYLOAD;
                        n_pos    = '0;
                        n_remain = body_len[WORD_W-2:0];
                    end
                end
            end
            PH_PAYLOAD: begin
                n_sum                  = sum_upd;
                n_remain               = r_remain - 31'd1;
                res.payload_valid      = 1'b1;
                res.payload_byte       = i_byte;
                res.payload_compressed = (r_scheme == SCHEME_COMP);
                if (r_remain == 31'd1) begin
                    res.payload_last = 1'b1;
                    n_phase          = PH_CHECK;
                    n_pos            = '0;
                end
            end
            PH_CHECK: begin
                n_pos = r_pos + 4'd1;
                case (r_pos[1:0])
                    2'd0:    n_expect[7:0]   = i_byte;
                    2'd1:    n_expect[15:8]  = i_byte;
                    default: n_expect[23:16] = i_byte;
                endcase
                if (r_pos == SUM_LAST) begin
                    res.status_valid = 1'b1;
                    if ({r_sum.high, r_sum.low} == {i_byte, r_expect}) begin
                        res.status = ST_OK;
                        n_phase    = PH_HEADER;
                        n_pos      = '0;
                        n_scheme   = '0;
                        n_total    = '0;
                        n_plain    = '0;
                        n_expect   = '0;
                        n_sum.low  = 16'd1;
                        n_sum.high = '0;
                    end else begin
                        res.status = ST_CHECKSUM;
                    end
                end
            end
            default: begin
            end
        endcase

        if (i_last && !res.status_valid && n_phase != PH_DROP &&
            !(n_phase == PH_HEADER && n_pos == '0)) begin
            res.status_valid = 1'b1;
            res.status       = (n_phase == PH_IDENT) ? ST_IDENT : ST_TRUNC;
        end

        if (i_last) begin
            n_phase    = PH_IDENT;
            n_pos      = '0;
            n_scheme   = '0;
            n_total    = '0;
            n_plain    = '0;
            n_remain   = '0;
            n_expect   = '0;
            n_sum.low  = 16'd1;
            n_sum.high = '0;
        end else if (res.status_valid && res.status != ST_OK) begin
            n_phase = PH_DROP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDENT;
            r_pos      <= '0;
            r_scheme   <= '0;
            r_total    <= '0;
            r_plain    <= '0;
            r_remain   <= '0;
            r_expect   <= '0;
            r_sum.low  <= 16'd1;
            r_sum.high <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_scheme <= n_scheme;
            r_total  <= n_total;
            r_plain  <= n_plain;
            r_remain <= n_remain;
            r_expect <= n_expect;
            r_sum    <= n_sum;
        end
    end

    assign o_res = res;

    a_pay_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.payload_valid |-> r_phase == PH_PAYLOAD)
        else $error("Payload beat produced outside the payload phase.");

    a_ok_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.status_valid && res.status == ST_OK |->
            r_phase == PH_CHECK && r_pos == SUM_LAST)
        else $error("Good section status without a complete checksum.");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_phase == PH_IDENT && r_pos == '0)
        else $error("Block did not restart after the final byte of a file.");

    a_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remain != '0)
        else $error("Payload phase entered with no bytes left.");

endmodule

`default_nettype wire

@@ sv/section_deframer_adler32_core.sv @@
// Top level of the Adler-32 checked section deframer: input register, parser
// and result register. Depends on sdfa_pkg, sdfa_if and sdfa_parse.
//
// The block takes one file byte per clock cycle unless a pending result beat
// stalls it, and presents its result, if any, on the output after the input
// register and the result register. Throughput is one byte per cycle while
// the output is not stalled, set by the parser updating its state once per
// byte with the Adler-32 add and its modulo reduction. Bytes that cause no result
// (identifier, header, checksum and dropped bytes) produce no output beat. The
// input stays ready while a result waits in the output register, as long as the
// byte held in the input register either produces no result or the output is
// taken. The input is not ready during reset.
`default_nettype none

module section_deframer_adler32_core
    import sdfa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sdfa_in_if.sink   i_in,
    sdfa_out_if.source o_out
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_out_valid;
    t_result           r_res;
    t_result           res;
    logic              res_any;
    logic              step;

    sdfa_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_res   (res)
    );

    assign res_any    = res.payload_valid | res.status_valid;
    assign step       = r_in_valid && (!r_out_valid || o_out.ready || !res_any);
    assign i_in.ready = i_rst_n && (!r_in_valid || step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_any) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_any) begin
            r_res <= res;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.payload_valid      = r_res.payload_valid;
    assign o_out.payload_byte       = r_res.payload_byte;
    assign o_out.payload_compressed = r_res.payload_compressed;
    assign o_out.payload_last       = r_res.payload_last;
    assign o_out.status_valid       = r_res.status_valid;
    assign o_out.status             = r_res.status;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready && r_in_valid && res_any |-> !step)
        else $error("Pending result beat overwritten by a new one.");

    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res.payload_valid || r_res.status_valid)
        else $error("Output beat carries neither payload nor status.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_byte) && $stable(r_last))
        else $error("Held input byte lost before it was processed.");

endmodule

`default_nettype wire
